// ===== design/hcbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and codes for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] body_byte;
		logic       byte_valid;
		logic       done_res;
		logic [1:0] error_code;
		logic       leftover;
	} out_item_t;

	// byte class computed by the front part
	typedef struct packed {
		logic       is_begin;
		logic       is_hex;
		logic [3:0] hex_val;
		logic       is_semi;
		logic       is_cr;
		logic       is_lf;
		logic [7:0] data_byte;
	} cls_item_t;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_BAD   = 2'd1;
	localparam logic [1:0] ERR_LARGE = 2'd2;

	localparam logic [1:0] CFG_CHUNKED = 2'd0;
	localparam logic [1:0] CFG_LENGTH  = 2'd1;
	localparam logic [1:0] CFG_MAXBODY = 2'd2;

	localparam logic [3:0] PH_BEGIN   = 4'd0;
	localparam logic [3:0] PH_FIXED   = 4'd1;
	localparam logic [3:0] PH_SIZE    = 4'd2;
	localparam logic [3:0] PH_EXT     = 4'd3;
	localparam logic [3:0] PH_SIZE_LF = 4'd4;
	localparam logic [3:0] PH_DATA    = 4'd5;
	localparam logic [3:0] PH_DATA_CR = 4'd6;
	localparam logic [3:0] PH_DATA_LF = 4'd7;
	localparam logic [3:0] PH_LAST_CR = 4'd8;
	localparam logic [3:0] PH_LAST_LF = 4'd9;
	localparam logic [3:0] PH_DONE    = 4'd10;
	localparam logic [3:0] PH_ERROR   = 4'd11;

	localparam logic [7:0] CH_SEMI = 8'h3b;
	localparam logic [7:0] CH_CR   = 8'h0d;
	localparam logic [7:0] CH_LF   = 8'h0a;

	localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

endpackage

// ===== design/hcbd_front.sv =====
// ----------------------------------------------------------------------------
// hcbd_front
// Accepts raw requests, classifies the byte and feeds a two-entry queue.
// ----------------------------------------------------------------------------
module hcbd_front import hcbd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      q_valid,
	input  logic      q_ready,
	output cls_item_t q_data
);

	cls_item_t  mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	cls_item_t  cls;
	logic [7:0] c;
	logic       push, pop;

	// byte classification
	always_comb begin
		c = in_data.data_byte;
		cls = '0;
		cls.is_begin = in_data.operation;
		cls.data_byte = c;
		cls.is_semi = (c == CH_SEMI);
		cls.is_cr = (c == CH_CR);
		cls.is_lf = (c == CH_LF);
		if (c >= 8'h30 && c <= 8'h39) begin
			cls.is_hex = 1'b1;
			cls.hex_val = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			cls.is_hex = 1'b1;
			cls.hex_val = c[3:0] + 4'd9;
		end
	end

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = mem_q[rd_q];
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2)
		else $error("full queue lost entry");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 && push) |=> q_valid)
		else $error("push not visible");

endmodule

// ===== design/hcbd_back.sv =====
// ----------------------------------------------------------------------------
// hcbd_back
// Phase machine and counters; one classified byte a cycle, unless the output stalls, into an output reg.
// ----------------------------------------------------------------------------
module hcbd_back import hcbd_pkg::*; #(
	parameter int COUNT_BITS     = 32,
	parameter int MAX_HEX_DIGITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_ready,
	input  cls_item_t   q_data,
	input  logic        chunked_mode,
	input  logic [31:0] content_length,
	input  logic [31:0] max_body,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data
);

	localparam int DW = $clog2(MAX_HEX_DIGITS + 1);
	localparam int AW = 4 * MAX_HEX_DIGITS;
	localparam int LW = (COUNT_BITS > 32) ? COUNT_BITS : 32;

	logic [3:0]            phase_q, ph;
	logic [AW-1:0]         acc_q, acc;
	logic [DW-1:0]         dcnt_q, dcnt;
	logic [COUNT_BITS-1:0] rem_q, rem, tot_q, tot;
	logic [1:0]            err_q, err;
	logic [COUNT_BITS-1:0] limit;
	logic [LW-1:0]         mb_ext;
	logic [63:0]           acc_cmp, room_cmp;
	logic                  valid, left, take;

	// effective limit: min of max_body and count range
	always_comb begin
		mb_ext = LW'(max_body);
		if (mb_ext > LW'({COUNT_BITS{1'b1}})) limit = '1;
		else limit = mb_ext[COUNT_BITS-1:0];
	end

	assign take = q_valid && (!out_valid || out_ready);
	assign q_ready = !out_valid || out_ready;

	// next-state logic
	always_comb begin
		ph = phase_q; acc = acc_q; dcnt = dcnt_q; rem = rem_q; tot = tot_q; err = err_q;
		valid = 1'b0; left = 1'b0;
		acc_cmp = '0; room_cmp = '0;
		if (q_data.is_begin || phase_q == PH_BEGIN) begin
			acc = '0; dcnt = '0; rem = '0; tot = '0; err = ERR_NONE;
			if (chunked_mode) begin
				ph = PH_SIZE;
			end else if (LW'(content_length) > LW'(limit)) begin
				ph = PH_ERROR; err = ERR_LARGE;
			end else if (content_length == 32'd0) begin
				ph = PH_DONE;
			end else begin
				rem = COUNT_BITS'(LW'(content_length));
				ph = PH_FIXED;
			end
		end
		if (!q_data.is_begin) begin
			case (ph)
				PH_FIXED, PH_DATA: begin
					valid = 1'b1;
					tot = tot + 1'b1;
					rem = rem - 1'b1;
					if (rem == '0) ph = (ph == PH_FIXED) ? PH_DONE : PH_DATA_CR;
				end
				PH_SIZE: begin
					if (q_data.is_hex) begin
						if (32'(dcnt) >= 32'(MAX_HEX_DIGITS)) begin
							ph = PH_ERROR; err = ERR_BAD;
						end else begin
							acc = {acc[AW-5:0], q_data.hex_val};
							dcnt = dcnt + 1'b1;
							// room left below the limit, wrapping at 64 bits
							acc_cmp = 64'(acc);
							room_cmp = 64'(limit) - 64'(tot);
							if (acc_cmp > room_cmp) begin
								ph = PH_ERROR; err = ERR_LARGE;
							end
						end
					end else if (q_data.is_semi && dcnt != '0) begin
						ph = PH_EXT;
					end else if (q_data.is_cr && dcnt != '0) begin
						ph = PH_SIZE_LF;
					end else begin
						ph = PH_ERROR; err = ERR_BAD;
					end
				end
				PH_EXT: if (q_data.is_cr) ph = PH_SIZE_LF;
				PH_SIZE_LF: begin
					if (!q_data.is_lf) begin
						ph = PH_ERROR; err = ERR_BAD;
					end else begin
						if (acc == '0) ph = PH_LAST_CR;
						else begin
							rem = COUNT_BITS'(acc);
							ph = PH_DATA;
						end
						acc = '0; dcnt = '0;
					end
				end
				PH_DATA_CR: if (q_data.is_cr) ph = PH_DATA_LF;
					else begin ph = PH_ERROR; err = ERR_BAD; end
				PH_DATA_LF: if (q_data.is_lf) ph = PH_SIZE;
					else begin ph = PH_ERROR; err = ERR_BAD; end
				PH_LAST_CR: if (q_data.is_cr) ph = PH_LAST_LF;
					else begin ph = PH_ERROR; err = ERR_BAD; end
				PH_LAST_LF: if (q_data.is_lf) ph = PH_DONE;
					else begin ph = PH_ERROR; err = ERR_BAD; end
				default: left = 1'b1;
			endcase
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BEGIN;
			acc_q <= '0; dcnt_q <= '0; rem_q <= '0; tot_q <= '0; err_q <= ERR_NONE;
			out_valid <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= ph; acc_q <= acc; dcnt_q <= dcnt;
				rem_q <= rem; tot_q <= tot; err_q <= err;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (take) begin
			out_data.body_byte <= valid ? q_data.data_byte : 8'd0;
			out_data.byte_valid <= valid;
			out_data.done_res <= (ph == PH_DONE);
			out_data.error_code <= err;
			out_data.leftover <= left;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ERROR) |-> err_q != ERR_NONE)
		else $error("error phase without code");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.byte_valid) |-> !out_data.leftover)
		else $error("valid byte marked leftover");
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_ERROR && phase_q != PH_BEGIN) |-> err_q == ERR_NONE)
		else $error("error code outside error phase");

endmodule

// ===== design/http_chunked_body_decoder.sv =====
// path: an accepted request is written into the front queue, then decoded
// into the back's output register, from which its result can be taken
// throughput: one request per cycle while the output is not stalled, set by the phase update
// the two-entry queue between front and back absorbs output stalls
// reset: phase returns to begin-of-body, counters and error clear,
// registers reload defaults (max_body 1048576)
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes fixed-length or chunked HTTP bodies, one byte per request.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder import hcbd_pkg::*; #(
	parameter int COUNT_BITS     = 32,
	parameter int MAX_HEX_DIGITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic        chunked_q;
	logic [31:0] length_q, maxbody_q;
	logic        q_valid, q_ready;
	cls_item_t   q_data;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunked_q <= 1'b0;
			length_q <= '0;
			maxbody_q <= MAX_BODY_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CHUNKED: chunked_q <= cfg_data[0];
				CFG_LENGTH:  length_q <= cfg_data;
				CFG_MAXBODY: maxbody_q <= cfg_data;
				default: ;
			endcase
		end
	end

	hcbd_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
	);

	hcbd_back #(.COUNT_BITS(COUNT_BITS), .MAX_HEX_DIGITS(MAX_HEX_DIGITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
		.chunked_mode(chunked_q), .content_length(length_q), .max_body(maxbody_q),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

endmodule

// ===== tb/tb_http_chunked_body_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder
// Drives fixed-length and chunked bodies, with random gaps and output stalls,
// and checks every decoded result against an in-bench decoder model.
// ----------------------------------------------------------------------------
module tb_http_chunked_body_decoder;
	import hcbd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	http_chunked_body_decoder uut (.*);

	always #5 clk = ~clk;

	// decoder model state
	logic cm_chunked;
	logic [31:0] cm_length, cm_maxbody;
	logic [3:0] dm_phase;
	logic [63:0] dm_hex, dm_remaining, dm_total;
	int dm_digits;
	logic [1:0] dm_err;

	in_item_t pending_bytes[$];
	out_item_t expected_bytes[$];
	int errors = 0;
	int accepted = 0, checked = 0, n_done = 0, n_err = 0;
	bit hold_long = 0;
	bit pause_send = 0;
	int idle_cycles = 0;
	bit wd_fired = 0;

	function automatic logic [63:0] eff_limit();
		return {32'd0, cm_maxbody};
	endfunction

	function automatic void start_body();
		dm_hex = 0;
		dm_digits = 0;
		dm_remaining = 0;
		dm_total = 0;
		dm_err = ERR_NONE;
		if (cm_chunked)
			dm_phase = PH_SIZE;
		else if ({32'd0, cm_length} > eff_limit()) begin
			dm_err = ERR_LARGE;
			dm_phase = PH_ERROR;
		end else if (cm_length == 0)
			dm_phase = PH_DONE;
		else begin
			dm_remaining = {32'd0, cm_length};
			dm_phase = PH_FIXED;
		end
	endfunction

	function automatic void raise_err(logic [1:0] code);
		dm_err = code;
		dm_phase = PH_ERROR;
	endfunction

	function automatic out_item_t decode_byte(in_item_t it);
		out_item_t r;
		logic [7:0] c;
		logic vld, left;
		int hv;
		c = it.data_byte;
		vld = 0;
		left = 0;
		hv = -1;
		if (c >= "0" && c <= "9") hv = c - "0";
		else if (c >= "a" && c <= "f") hv = c - "a" + 10;
		else if (c >= "A" && c <= "F") hv = c - "A" + 10;
		if (it.operation) start_body();
		else begin
			if (dm_phase == PH_BEGIN) start_body();
			case (dm_phase)
				PH_FIXED, PH_DATA: begin
					vld = 1;
					dm_total = (dm_total + 1) & 64'hffff_ffff;
					dm_remaining = (dm_remaining - 1) & 64'hffff_ffff;
					if (dm_remaining == 0)
						dm_phase = (dm_phase == PH_FIXED) ? PH_DONE : PH_DATA_CR;
				end
				PH_SIZE: begin
					if (hv >= 0) begin
						if (dm_digits >= 16) raise_err(ERR_BAD);
						else begin
							dm_hex = (dm_hex << 4) | hv;
							dm_digits++;
							if (dm_hex > eff_limit() - dm_total) raise_err(ERR_LARGE);
						end
					end else if (c == CH_SEMI && dm_digits > 0) dm_phase = PH_EXT;
					else if (c == CH_CR && dm_digits > 0) dm_phase = PH_SIZE_LF;
					else raise_err(ERR_BAD);
				end
				PH_EXT: if (c == CH_CR) dm_phase = PH_SIZE_LF;
				PH_SIZE_LF: begin
					if (c != CH_LF) raise_err(ERR_BAD);
					else begin
						if (dm_hex == 0) dm_phase = PH_LAST_CR;
						else begin
							dm_remaining = dm_hex & 64'hffff_ffff;
							dm_phase = PH_DATA;
						end
						dm_hex = 0;
						dm_digits = 0;
					end
				end
				PH_DATA_CR: if (c == CH_CR) dm_phase = PH_DATA_LF; else raise_err(ERR_BAD);
				PH_DATA_LF: if (c == CH_LF) dm_phase = PH_SIZE; else raise_err(ERR_BAD);
				PH_LAST_CR: if (c == CH_CR) dm_phase = PH_LAST_LF; else raise_err(ERR_BAD);
				PH_LAST_LF: if (c == CH_LF) dm_phase = PH_DONE; else raise_err(ERR_BAD);
				default: left = 1;
			endcase
		end
		r.body_byte = vld ? c : 8'd0;
		r.byte_valid = vld;
		r.done_res = (dm_phase == PH_DONE);
		r.error_code = dm_err;
		r.leftover = left;
		return r;
	endfunction

	// request driver: bursts with random gaps
	int burst_left = 0, gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_bytes.push_back(decode_byte(in_data));
				accepted++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0 || pause_send || pending_bytes.size() == 0) begin
					in_valid <= 1'b0;
					if (gap_left > 0) gap_left--;
				end else begin
					in_valid <= 1'b1;
					in_data <= pending_bytes.pop_front();
					if (burst_left > 0) burst_left--;
					else begin
						burst_left = $urandom_range(0, 20);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
					end
				end
			end
		end
	end

	// result monitor and receiver stall pattern
	int stall_phase = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_data);
					errors++;
				end else begin
					out_item_t e;
					e = expected_bytes.pop_front();
					if (e !== out_data) begin
						$display("%0t: mismatch expected %p actual %p", $time, e, out_data);
						errors++;
					end
					checked++;
					if (out_data.done_res) n_done++;
					if (out_data.error_code != ERR_NONE) n_err++;
				end
			end
			stall_phase++;
			out_ready <= !hold_long && (stall_phase % 16 < 10 ? 1'b1 : 1'($urandom_range(0, 1)));
		end
	end

	// watchdog on accepted traffic
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n || hold_long)
			idle_cycles <= 0;
		else if (expected_bytes.size() != 0 || pending_bytes.size() != 0) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WATCHDOG && !wd_fired) begin
				wd_fired = 1;
				$display("tb_http_chunked_body_decoder NOT OK");
				$finish;
			end
		end
	end

	task automatic push_byte(logic op, logic [7:0] b);
		in_item_t it;
		it.operation = op;
		it.data_byte = b;
		pending_bytes.push_back(it);
	endtask

	task automatic push_hex(logic [31:0] v, int digits);
		for (int i = digits - 1; i >= 0; i--) begin
			logic [3:0] d;
			d = 4'(v >> (4 * i));
			if (d < 10) push_byte(1'b0, 8'("0" + d));
			else push_byte(1'b0, 8'(($urandom_range(0, 1) ? "a" : "A") + d - 10));
		end
	endtask

	// one well-formed chunked body with random content, optionally broken
	task automatic push_chunked_body(bit broken);
		int chunks;
		push_byte(1'b1, 8'($urandom));
		chunks = $urandom_range(0, 3);
		for (int k = 0; k < chunks; k++) begin
			int sz;
			sz = $urandom_range(1, 12);
			push_hex(sz, $urandom_range(1, 3));
			if ($urandom_range(0, 3) == 0) begin
				push_byte(1'b0, CH_SEMI);
				repeat ($urandom_range(0, 4)) push_byte(1'b0, 8'($urandom_range(32, 126)));
			end
			push_byte(1'b0, CH_CR);
			push_byte(1'b0, CH_LF);
			repeat (sz) push_byte(1'b0, 8'($urandom));
			push_byte(1'b0, CH_CR);
			push_byte(1'b0, CH_LF);
		end
		push_hex(0, $urandom_range(1, 2));
		push_byte(1'b0, CH_CR);
		if (broken) push_byte(1'b0, 8'($urandom));
		else push_byte(1'b0, CH_LF);
		repeat ($urandom_range(0, 2)) push_byte(1'b0, 8'($urandom));
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_CHUNKED: cm_chunked = val[0];
			CFG_LENGTH: cm_length = val;
			default: cm_maxbody = val;
		endcase
	endtask

	task automatic drain();
		while (pending_bytes.size() != 0 || in_valid || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		cm_chunked = 0;
		cm_length = 0;
		cm_maxbody = MAX_BODY_RESET;
		dm_phase = PH_BEGIN;
		dm_hex = 0;
		dm_digits = 0;
		dm_remaining = 0;
		dm_total = 0;
		dm_err = ERR_NONE;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// data before any begin, reset config: length zero completes at once
		push_byte(1'b0, 8'h00);
		push_byte(1'b0, 8'hff);
		drain();

		// fixed length, including limit overflow
		write_reg(CFG_LENGTH, 3);
		push_byte(1'b1, 8'h55);
		repeat (4) push_byte(1'b0, 8'($urandom));
		drain();
		write_reg(CFG_MAXBODY, 2);
		push_byte(1'b1, 8'h00);
		push_byte(1'b0, 8'h11);
		drain();

		// chunked directed cases
		write_reg(CFG_MAXBODY, 32'hffff_ffff);
		write_reg(CFG_CHUNKED, 1);
		push_byte(1'b1, 8'h00);
		push_byte(1'b0, CH_CR);
		push_byte(1'b1, 8'h00);
		push_byte(1'b0, "g");
		push_byte(1'b1, 8'h00);
		repeat (17) push_byte(1'b0, "0");
		push_byte(1'b1, 8'h00);
		push_hex(32'hffff_ffff, 8);
		push_byte(1'b0, "F");
		drain();
		write_reg(CFG_MAXBODY, 0);
		push_byte(1'b1, 8'h00);
		push_byte(1'b0, "1");
		push_byte(1'b1, 8'h00);
		push_byte(1'b0, "0");
		push_byte(1'b0, CH_SEMI);
		push_byte(1'b0, "x");
		push_byte(1'b0, CH_CR);
		push_byte(1'b0, "x");
		drain();

		// random phases over several settings
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(CFG_CHUNKED, ph % 3 != 2);
			write_reg(CFG_MAXBODY, (ph == 4) ? 20 : $urandom_range(30, 1 << 20));
			write_reg(CFG_LENGTH, (ph == 5) ? 32'hffff_ffff : $urandom_range(0, 15));
			if (ph == 1) hold_long = 1;
			while (pending_bytes.size() < 60) begin
				case ($urandom_range(0, 9))
					0: push_byte(1'($urandom), 8'($urandom));
					1: push_chunked_body(1);
					default: push_chunked_body(0);
				endcase
			end
			if (ph == 1) begin
				repeat (200) @(posedge clk);
				hold_long = 0;
			end
			if (ph == 3) begin
				// stop sending mid-stream until every result is back
				repeat (30) @(posedge clk);
				pause_send = 1;
				while (expected_bytes.size() != 0 || in_valid) @(posedge clk);
				pause_send = 0;
			end
			drain();
		end

		repeat (10) @(posedge clk);
		$display("checked %0d results over %0d requests", checked, accepted);
		$display("%0d results marked done, %0d with an error code", n_done, n_err);
		if (errors == 0 && expected_bytes.size() == 0)
			$display("tb_http_chunked_body_decoder OK");
		else
			$display("tb_http_chunked_body_decoder NOT OK");
		$finish;
	end
endmodule

// ===== sim.f =====
design/hcbd_pkg.sv
design/hcbd_front.sv
design/hcbd_back.sv
design/http_chunked_body_decoder.sv
tb/tb_http_chunked_body_decoder.sv
